>>> src/sle_pkg.sv
package sle_pkg;

  localparam int CMD_W      = 2;
  localparam int POS_W      = 7;
  localparam int NAME_W     = 64;
  localparam int NUM_W      = 37;
  localparam int STATUS_W   = 2;
  localparam int CAPACITY_DEF = 64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [NUM_W-1:0]  number;
  } entry_t;

  // broadcast operation for the cell row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

endpackage

>>> src/sle_cell.sv
module sle_cell #(
  parameter int IDXW  = 6,
  parameter int INDEX = 0
) (
  input  logic              clk_i,
  input  sle_pkg::cell_op_e op_i,
  input  logic [IDXW-1:0]   slot_i,
  input  sle_pkg::entry_t   prev_i,
  input  sle_pkg::entry_t   next_i,
  input  sle_pkg::entry_t   new_i,
  output sle_pkg::entry_t   entry_o
);

  localparam logic [IDXW-1:0] MY_IDX = IDXW'(INDEX);

  sle_pkg::entry_t entry_q;
  sle_pkg::entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      sle_pkg::CELL_INS: begin
        if (MY_IDX > slot_i) begin
          entry_d = prev_i;
        end else if (MY_IDX == slot_i) begin
          entry_d = new_i;
        end
      end
      sle_pkg::CELL_DEL: begin
        if (MY_IDX >= slot_i) begin
          entry_d = next_i;
        end
      end
      sle_pkg::CELL_ROT: begin
        entry_d = next_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // list contents: no reset, undefined until written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> src/sle_cell_row.sv
module sle_cell_row #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
  parameter int IDXW     = $clog2(CAPACITY)
) (
  input  logic              clk_i,
  input  sle_pkg::cell_op_e op_i,
  input  logic [IDXW-1:0]   slot_i,
  input  sle_pkg::entry_t   new_i,
  output sle_pkg::entry_t   head_o
);

  sle_pkg::entry_t entries [CAPACITY];

  // ring: cell i hears cell i-1 (cell 0 hears itself) and cell i+1, last cell wraps to cell 0
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == CAPACITY - 1) ? 0 : g + 1;

    sle_cell #(
      .IDXW  (IDXW),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op_i),
      .slot_i  (slot_i),
      .prev_i  (entries[PREV]),
      .next_i  (entries[NEXT]),
      .new_i   (new_i),
      .entry_o (entries[g])
    );
  end

  assign head_o = entries[0];

endmodule

>>> src/sequential_list_engine_core.sv
// Ordered list engine, one transaction in flight at a time.
// Sequence: a rejected command goes straight to S_RESP, insert passes S_INSERT then
//   S_RESP; get and locate pass S_SCAN then S_RESP; delete passes S_SCAN, S_CLOSE
//   and S_RESP. S_SCAN is the full ring rotation of the cell row past its head cell.
// Throughput: next transaction accepted the cycle after the result is registered;
//   a stalled result still held in the output register delays that further.
// Reset (rst_ni low, async): count and control cleared; list contents not reset.
module sequential_list_engine_core #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sle_pkg::CMD_W-1:0]     cmd_i,
  input  logic [sle_pkg::POS_W-1:0]     position_i,
  input  logic [sle_pkg::NAME_W-1:0]    name_key_i,
  input  logic [sle_pkg::NUM_W-1:0]     phone_number_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sle_pkg::STATUS_W-1:0]  status_o,
  output logic [sle_pkg::NAME_W-1:0]    out_name_o,
  output logic [sle_pkg::NUM_W-1:0]     out_number_o,
  output logic [sle_pkg::POS_W-1:0]     found_position_o,
  output logic [sle_pkg::POS_W-1:0]     entry_count_o
);

  // count holds 0..CAPACITY, slot/step index 0..CAPACITY-1
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int IDXW = $clog2(CAPACITY);
  // common compare width, room for count+1 and the 7-bit position
  localparam int WW   = ((CNTW > sle_pkg::POS_W) ? CNTW : sle_pkg::POS_W) + 1;
  localparam logic [IDXW-1:0] LAST_STEP = IDXW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,  // shift up from the slot
    S_SCAN,    // full rotation, head cell inspected each cycle
    S_CLOSE,   // shift down to close the gap after delete
    S_RESP     // hand result to the output register
  } state_e;

  state_e                          state_q;
  logic [CNTW-1:0]                 count_q;
  logic [sle_pkg::CMD_W-1:0]       cmd_q;
  logic [IDXW-1:0]                 slot_q;
  logic [IDXW-1:0]                 step_q;
  logic [sle_pkg::NAME_W-1:0]      key_q;
  logic [sle_pkg::NUM_W-1:0]       num_q;
  logic [sle_pkg::STATUS_W-1:0]    res_status_q;
  logic [sle_pkg::NAME_W-1:0]      res_name_q;
  logic [sle_pkg::NUM_W-1:0]       res_num_q;
  logic [sle_pkg::POS_W-1:0]       res_found_q;
  logic                            hit_q;

  logic                            out_valid_q;
  logic [sle_pkg::STATUS_W-1:0]    status_q;
  logic [sle_pkg::NAME_W-1:0]      out_name_q;
  logic [sle_pkg::NUM_W-1:0]       out_number_q;
  logic [sle_pkg::POS_W-1:0]       found_q;
  logic [sle_pkg::POS_W-1:0]       entry_count_q;

  logic                            in_fire;
  logic                            out_free;
  logic                            out_load;
  logic [WW-1:0]                   cnt_w;
  logic [WW-1:0]                   pos_w;
  logic [WW-1:0]                   pos_m1;
  logic [WW-1:0]                   step_w;
  logic [WW-1:0]                   step_p1;
  logic                            full;
  logic                            ins_bad;
  logic                            rd_bad;
  logic                            head_match;
  logic                            in_list;
  logic [sle_pkg::STATUS_W-1:0]    start_status;
  state_e                          start_state;

  sle_pkg::cell_op_e               row_op;
  sle_pkg::entry_t                 row_new;
  sle_pkg::entry_t                 head;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  // output register can take a new result when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_RESP) && out_free;

  assign cnt_w   = WW'(count_q);
  assign pos_w   = WW'(position_i);
  assign pos_m1  = pos_w - WW'(1);
  assign step_w  = WW'(step_q);
  assign step_p1 = step_w + WW'(1);

  assign full    = (cnt_w == WW'(CAPACITY));
  assign ins_bad = (pos_w == '0) || (pos_w > cnt_w + WW'(1));
  assign rd_bad  = (pos_w == '0) || (pos_w > cnt_w);

  // head cell holds original entry step_q during the rotation
  assign head_match = (head.name == key_q) && (head.number == num_q);
  assign in_list    = (step_w < cnt_w);

  // decode of an incoming command: early status and first state
  always_comb begin
    start_status = sle_pkg::ST_OK;
    start_state  = S_RESP;
    case (cmd_i)
      sle_pkg::CMD_INSERT: begin
        if (full) begin
          start_status = sle_pkg::ST_OVER;
        end else if (ins_bad) begin
          start_status = sle_pkg::ST_BADPOS;
        end else begin
          start_state = S_INSERT;
        end
      end
      sle_pkg::CMD_DELETE: begin
        // empty test wins over the position test
        if (cnt_w == '0) begin
          start_status = sle_pkg::ST_UNDER;
        end else if (rd_bad) begin
          start_status = sle_pkg::ST_BADPOS;
        end else begin
          start_state = S_SCAN;
        end
      end
      sle_pkg::CMD_GET: begin
        if (rd_bad) begin
          start_status = sle_pkg::ST_BADPOS;
        end else begin
          start_state = S_SCAN;
        end
      end
      default: begin
        start_state = S_SCAN;
      end
    endcase
  end

  // broadcast to the cell row
  always_comb begin
    case (state_q)
      S_INSERT: row_op = sle_pkg::CELL_INS;
      S_SCAN:   row_op = sle_pkg::CELL_ROT;
      S_CLOSE:  row_op = sle_pkg::CELL_DEL;
      default:  row_op = sle_pkg::CELL_HOLD;
    endcase
  end

  assign row_new.name   = key_q;
  assign row_new.number = num_q;

  sle_cell_row #(
    .CAPACITY (CAPACITY),
    .IDXW     (IDXW)
  ) u_row (
    .clk_i  (clk_i),
    .op_i   (row_op),
    .slot_i (slot_q),
    .new_i  (row_new),
    .head_o (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      cmd_q         <= sle_pkg::CMD_INSERT;
      slot_q        <= '0;
      step_q        <= '0;
      key_q         <= '0;
      num_q         <= '0;
      res_status_q  <= sle_pkg::ST_OK;
      res_name_q    <= '0;
      res_num_q     <= '0;
      res_found_q   <= '0;
      hit_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      status_q      <= sle_pkg::ST_OK;
      out_name_q    <= '0;
      out_number_q  <= '0;
      found_q       <= '0;
      entry_count_q <= '0;
    end else begin
      // load or drain the output register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q        <= cmd_i;
            slot_q       <= pos_m1[IDXW-1:0];
            key_q        <= name_key_i;
            num_q        <= phone_number_i;
            step_q       <= '0;
            hit_q        <= 1'b0;
            res_name_q   <= '0;
            res_num_q    <= '0;
            res_found_q  <= '0;
            res_status_q <= start_status;
            state_q      <= start_state;
          end
        end

        S_INSERT: begin
          count_q <= count_q + CNTW'(1);
          state_q <= S_RESP;
        end

        S_SCAN: begin
          if (cmd_q == sle_pkg::CMD_LOCATE) begin
            // first match only
            if (!hit_q && in_list && head_match) begin
              hit_q       <= 1'b1;
              res_found_q <= step_p1[sle_pkg::POS_W-1:0];
            end
          end else if (step_q == slot_q) begin
            res_name_q <= head.name;
            res_num_q  <= head.number;
          end
          step_q <= step_q + IDXW'(1);
          if (step_q == LAST_STEP) begin
            state_q <= (cmd_q == sle_pkg::CMD_DELETE) ? S_CLOSE : S_RESP;
          end
        end

        S_CLOSE: begin
          count_q <= count_q - CNTW'(1);
          state_q <= S_RESP;
        end

        S_RESP: begin
          if (out_free) begin
            status_q      <= res_status_q;
            out_name_q    <= res_name_q;
            out_number_q  <= res_num_q;
            found_q       <= res_found_q;
            entry_count_q <= cnt_w[sle_pkg::POS_W-1:0];
            state_q       <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_name_o       = out_name_q;
  assign out_number_o     = out_number_q;
  assign found_position_o = found_q;
  assign entry_count_o    = entry_count_q;

`ifndef SYNTHESIS
  // list never grows past its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("count above capacity");

  // count moves only in the shift states
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_SCAN || state_q == S_RESP) |=> $stable(count_q))
    else $error("count changed outside insert or close");

  // an accepted transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("accepted transaction not started");
`endif

endmodule

>>> verif/sequential_list_engine_core_test.sv
// Testbench for the ordered list engine.
// Each command transaction is predicted against a queue-based copy of the list
// and each result transaction is compared field by field with the oldest prediction.
// A short directed sweep covers the boundary cases of every command. After that
// come random phases that fill the list to overflow, drain it to underflow, and
// mix all four commands in between.
module sequential_list_engine_core_test;

  localparam int CAPACITY = sle_pkg::CAPACITY_DEF;
  localparam logic [sle_pkg::NUM_W-1:0] NUM_MAX = 37'd99999999999;
  localparam int PHASE_ITEMS = 140;

  // One predicted result transaction.
  typedef struct packed {
    logic [sle_pkg::STATUS_W-1:0] status;
    logic [sle_pkg::NAME_W-1:0]   name;
    logic [sle_pkg::NUM_W-1:0]    number;
    logic [sle_pkg::POS_W-1:0]    found_at;
    logic [sle_pkg::POS_W-1:0]    held;
  } list_result_t;

  // Mirror of the list contents plus the queue of results still owed by the block.
  class list_scoreboard;
    sle_pkg::entry_t entries[$];
    list_result_t    owed_q[$];
    int unsigned     failures;

    function new();
      failures = 0;
    endfunction

    // Apply one accepted command to the mirror and queue its result.
    function void note_command(logic [sle_pkg::CMD_W-1:0] cmd,
                               logic [sle_pkg::POS_W-1:0] pos,
                               logic [sle_pkg::NAME_W-1:0] key,
                               logic [sle_pkg::NUM_W-1:0] num);
      list_result_t    res;
      sle_pkg::entry_t ent;
      int unsigned     cnt;
      res = '0;
      cnt = entries.size();
      case (cmd)
        sle_pkg::CMD_INSERT: begin
          if (cnt >= CAPACITY) begin
            res.status = sle_pkg::ST_OVER;
          end else if (pos == 0 || pos > cnt + 1) begin
            res.status = sle_pkg::ST_BADPOS;
          end else begin
            ent.name   = key;
            ent.number = num;
            entries.insert(pos - 1, ent);
          end
        end
        sle_pkg::CMD_DELETE: begin
          // empty list wins over a bad position
          if (cnt == 0) begin
            res.status = sle_pkg::ST_UNDER;
          end else if (pos == 0 || pos > cnt) begin
            res.status = sle_pkg::ST_BADPOS;
          end else begin
            res.name   = entries[pos - 1].name;
            res.number = entries[pos - 1].number;
            entries.delete(pos - 1);
          end
        end
        sle_pkg::CMD_GET: begin
          if (pos == 0 || pos > cnt) begin
            res.status = sle_pkg::ST_BADPOS;
          end else begin
            res.name   = entries[pos - 1].name;
            res.number = entries[pos - 1].number;
          end
        end
        default: begin
          // locate: first entry where both name and number match
          for (int j = 0; j < cnt; j++) begin
            if (entries[j].name == key && entries[j].number == num) begin
              res.found_at = sle_pkg::POS_W'(j + 1);
              break;
            end
          end
        end
      endcase
      res.held = sle_pkg::POS_W'(entries.size());
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [sle_pkg::STATUS_W-1:0] status,
                               logic [sle_pkg::NAME_W-1:0] name,
                               logic [sle_pkg::NUM_W-1:0] number,
                               logic [sle_pkg::POS_W-1:0] found_at,
                               logic [sle_pkg::POS_W-1:0] held);
      list_result_t want;
      if (owed_q.size() == 0) begin
        $error("result transaction with no prediction pending");
        failures++;
        return;
      end
      want = owed_q.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        failures++;
      end
      if (name !== want.name) begin
        $error("out_name: expected %h, actual %h", want.name, name);
        failures++;
      end
      if (number !== want.number) begin
        $error("out_number: expected %0d, actual %0d", want.number, number);
        failures++;
      end
      if (found_at !== want.found_at) begin
        $error("found_position: expected %0d, actual %0d", want.found_at, found_at);
        failures++;
      end
      if (held !== want.held) begin
        $error("entry_count: expected %0d, actual %0d", want.held, held);
        failures++;
      end
    endfunction
  endclass

  // Every input starts at a known value.
  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic [sle_pkg::CMD_W-1:0]    cmd_i          = sle_pkg::CMD_GET;
  logic [sle_pkg::POS_W-1:0]    position_i     = '0;
  logic [sle_pkg::NAME_W-1:0]   name_key_i     = '0;
  logic [sle_pkg::NUM_W-1:0]    phone_number_i = '0;
  logic                         out_stall_i    = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic [sle_pkg::STATUS_W-1:0] status_o;
  logic [sle_pkg::NAME_W-1:0]   out_name_o;
  logic [sle_pkg::NUM_W-1:0]    out_number_o;
  logic [sle_pkg::POS_W-1:0]    found_position_o;
  logic [sle_pkg::POS_W-1:0]    entry_count_o;

  // While set, neither side idles: back-to-back transactions for a whole phase.
  logic steady = 1'b0;

  list_scoreboard sb = new();

  sequential_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .position_i       (position_i),
    .name_key_i       (name_key_i),
    .phone_number_i   (phone_number_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .out_name_o       (out_name_o),
    .out_number_o     (out_number_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side back-pressure: about 8% of cycles, none during a steady phase.
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 8);
  end

  // Result monitor. Reads happen before this edge's updates land, so the
  // handshake seen here is the one the block saw.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(status_o, out_name_o, out_number_o, found_position_o, entry_count_o);
    end
  end

  function automatic logic [sle_pkg::NUM_W-1:0] rand_number();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return sle_pkg::NUM_W'(raw % 64'd100000000000);
  endfunction

  // Present one command and hold it until the block takes it. Called on a
  // rising edge; returns on the edge where the transaction was accepted.
  task automatic send_command(input logic [sle_pkg::CMD_W-1:0] cmd,
                              input logic [sle_pkg::POS_W-1:0] pos,
                              input logic [sle_pkg::NAME_W-1:0] key,
                              input logic [sle_pkg::NUM_W-1:0] num);
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    position_i     <= pos;
    name_key_i     <= key;
    phone_number_i <= num;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(cmd, pos, key, num);
  endtask

  // Hold off the command side until every owed result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
  endtask

  // One random command. Percentages steer the list toward full or empty.
  task automatic random_command(input int unsigned ins_pct, input int unsigned del_pct);
    logic [sle_pkg::CMD_W-1:0]  cmd;
    logic [sle_pkg::POS_W-1:0]  pos;
    logic [sle_pkg::NAME_W-1:0] key;
    logic [sle_pkg::NUM_W-1:0]  num;
    sle_pkg::entry_t            pick;
    int unsigned                cnt;
    int unsigned                roll;
    cnt  = sb.entries.size();
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) cmd = sle_pkg::CMD_INSERT;
    else if (roll < ins_pct + del_pct) cmd = sle_pkg::CMD_DELETE;
    else if (roll < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2) cmd = sle_pkg::CMD_GET;
    else cmd = sle_pkg::CMD_LOCATE;

    key = {$urandom, $urandom};
    num = rand_number();
    // Reuse a stored entry often: locate hits and duplicate inserts.
    if (cnt > 0 && $urandom_range(0, 99) < 40) begin
      pick = sb.entries[$urandom_range(0, cnt - 1)];
      key  = pick.name;
      num  = pick.number;
      case ($urandom_range(0, 9))
        0: key[$urandom_range(0, sle_pkg::NAME_W - 1)] =
             ~key[$urandom_range(0, sle_pkg::NAME_W - 1)];
        1: num = rand_number();
        default: ;
      endcase
    end
    if ($urandom_range(0, 49) == 0) key = '1;
    if ($urandom_range(0, 49) == 0) key = '0;
    if ($urandom_range(0, 49) == 0) num = NUM_MAX;
    if ($urandom_range(0, 49) == 0) num = '0;

    roll = $urandom_range(0, 99);
    if (roll < 6) pos = '0;
    else if (roll < 12) pos = sle_pkg::POS_W'($urandom_range(0, 127));
    else if (cmd == sle_pkg::CMD_INSERT) pos = sle_pkg::POS_W'($urandom_range(1, cnt + 1));
    else pos = sle_pkg::POS_W'($urandom_range(1, (cnt > 0) ? cnt : 1));
    send_command(cmd, pos, key, num);
  endtask

  initial begin
    logic [sle_pkg::NAME_W-1:0] key_a;
    logic [sle_pkg::NAME_W-1:0] key_b;
    logic [sle_pkg::NUM_W-1:0]  num_a;
    key_a = 64'h0123_4567_89ab_cdef;
    key_b = 64'hfedc_ba98_7654_3210;
    num_a = 37'd12345678901;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sweep over the boundaries of each command.
    send_command(sle_pkg::CMD_GET,    7'd1,   '0, '0);          // get on empty list
    send_command(sle_pkg::CMD_DELETE, 7'd1,   '0, '0);          // delete on empty: underflow
    send_command(sle_pkg::CMD_DELETE, 7'd0,   '0, '0);          // underflow beats bad position
    send_command(sle_pkg::CMD_LOCATE, 7'd0,   '0, '0);          // locate in empty list
    send_command(sle_pkg::CMD_INSERT, 7'd0,   key_a, num_a);    // position zero
    send_command(sle_pkg::CMD_INSERT, 7'd2,   key_a, num_a);    // past count+1
    send_command(sle_pkg::CMD_INSERT, 7'd1,   '1, NUM_MAX);     // all-ones extremes
    send_command(sle_pkg::CMD_INSERT, 7'd2,   '0, '0);          // append at tail
    send_command(sle_pkg::CMD_INSERT, 7'd1,   key_a, num_a);    // push at head
    send_command(sle_pkg::CMD_INSERT, 7'd2,   key_b, num_a);    // middle
    send_command(sle_pkg::CMD_INSERT, 7'd127, key_b, NUM_MAX);  // far out of range
    send_command(sle_pkg::CMD_GET,    7'd0,   '0, '0);
    send_command(sle_pkg::CMD_GET,    7'd4,   '0, '0);          // last entry
    send_command(sle_pkg::CMD_GET,    7'd5,   '0, '0);          // one past the end
    send_command(sle_pkg::CMD_LOCATE, 7'd0,   '1, NUM_MAX);     // hit
    send_command(sle_pkg::CMD_LOCATE, 7'd0,   '1, '0);          // name matches, number not
    send_command(sle_pkg::CMD_INSERT, 7'd5,   key_a, num_a);    // duplicate at tail
    send_command(sle_pkg::CMD_LOCATE, 7'd0,   key_a, num_a);    // first of the duplicates
    send_command(sle_pkg::CMD_DELETE, 7'd0,   '0, '0);
    send_command(sle_pkg::CMD_DELETE, 7'd6,   '0, '0);          // one past the end
    send_command(sle_pkg::CMD_DELETE, 7'd1,   '0, '0);          // head
    send_command(sle_pkg::CMD_DELETE, 7'd4,   '0, '0);          // tail
    send_command(sle_pkg::CMD_DELETE, 7'd2,   '0, '0);          // middle
    send_command(sle_pkg::CMD_GET,    7'd127, '0, '0);
    drain_results();

    // Random phases: fill, mix, drain, mix, twice over. The mixed phase right
    // after the second fill runs with no idling at all.
    for (int p = 0; p < 8; p++) begin
      steady <= (p == 5);
      @(posedge clk_i);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case (p % 4)
          0:       random_command(70, 10);
          2:       random_command(10, 70);
          default: random_command(30, 25);
        endcase
      end
      drain_results();
    end
    steady <= 1'b0;

    // All results are in; let a full ring rotation pass to catch strays.
    repeat (CAPACITY + 10) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
